@@ sv/vpri_pkg.sv @@
// Shared types, codes and helpers for the video port register interface.
// No dependencies.
package vpri_pkg;

    localparam int VIDEO_MEM_DEPTH = 16384;
    localparam int PALETTE_DEPTH   = 32;
    localparam int NUM_MODE_REGS   = 11;
    localparam int ADDR_W          = $clog2(VIDEO_MEM_DEPTH);
    localparam int PAL_ADDR_W      = $clog2(PALETTE_DEPTH);
    localparam int MODE_IDX_W      = $clog2(NUM_MODE_REGS);
    localparam int COLOR_W         = 24;
    localparam int FRAME_LINE      = 193;

    // action codes carried in tuser
    localparam logic [2:0] ACT_CTRL_WR = 3'd0;
    localparam logic [2:0] ACT_DATA_WR = 3'd1;
    localparam logic [2:0] ACT_DATA_RD = 3'd2;
    localparam logic [2:0] ACT_STAT_RD = 3'd3;
    localparam logic [2:0] ACT_FLAGS   = 3'd4;
    localparam logic [2:0] ACT_LINE    = 3'd5;

    // second control byte, bits 7:6
    localparam logic [1:0] CODE_READ   = 2'b00;
    localparam logic [1:0] CODE_WRITE  = 2'b01;
    localparam logic [1:0] CODE_REG_WR = 2'b10;
    localparam logic [1:0] CODE_PAL_WR = 2'b11;

    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic clr_step;   // clear pass writes one entry
        logic fill;       // load read buffer from video memory output
        logic out_taken;  // downstream ready
    } t_dp_cmd;

    typedef struct packed {
        logic fill_req;   // presented item needs a read buffer refill
        logic clr_last;   // clear pass at last entry
        logic out_valid;  // output register occupied
    } t_dp_status;

    // 2-bit channels in steps of 0x55: replicating the pair gives v * 0x55
    function automatic logic [COLOR_W-1:0] expand_color(input logic [5:0] v);
        expand_color = {{4{v[1:0]}}, {4{v[3:2]}}, {4{v[5:4]}}};
    endfunction

endpackage

@@ sv/vpri_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-old).
// No dependencies.
module vpri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vpri_ctrl.sv @@
// Sequencer: memory clear after reset, item acceptance, read buffer refill.
// Depends on vpri_pkg.
module vpri_ctrl import vpri_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic       i_m_ready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_s_ready
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_FILL  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_ready;

    assign w_ready = (r_state == ST_IDLE) && (!i_sts.out_valid || i_m_ready);

    assign o_s_ready       = w_ready;
    assign o_cmd.accept    = w_ready && i_s_valid;
    assign o_cmd.clr_step  = (r_state == ST_CLEAR);
    assign o_cmd.fill      = (r_state == ST_FILL);
    assign o_cmd.out_taken = i_m_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.fill_req) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_fill_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.fill_req) |=> o_cmd.fill)
        else $error("refill did not follow read");
    a_fill_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill |=> (r_state == ST_IDLE))
        else $error("refill longer than one cycle");
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_cmd.clr_step) |-> $past(i_sts.clr_last))
        else $error("clear pass ended early");
`endif

endmodule

@@ sv/vpri_dp.sv @@
// Datapath: address latch, mode registers, flags, line counter, memories,
// output register. Depends on vpri_pkg and vpri_ram.
module vpri_dp import vpri_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_value,
    input  logic [8:0]  i_next_line,
    input  logic        i_set_overflow,
    input  logic        i_set_collision,
    output t_dp_status  o_sts,
    output logic [7:0]  o_read_data,
    output logic        o_irq,
    output logic        o_out_valid
);

    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_sbe, n_sbe;
    logic [7:0]         r_latch, n_latch;
    logic               r_psel, n_psel;
    logic [7:0]         r_rbuf, n_rbuf;
    logic [2:0]         r_flags, n_flags;  // frame, overflow, collision
    logic               r_lf, n_lf;
    logic [7:0]         r_mode [NUM_MODE_REGS];
    logic [7:0]         n_mode [NUM_MODE_REGS];
    logic [7:0]         r_cd, n_cd;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_out_valid;
    logic [7:0]         r_out_rd;
    logic               r_out_irq;
    logic [PAL_ADDR_W-1:0] r_pal_raddr;

    logic [7:0]         w_rd;
    logic               w_irq;
    logic [ADDR_W-1:0]  w_ctl_addr;
    logic [ADDR_W-1:0]  w_fill_addr;
    logic [1:0]         w_code;
    logic [MODE_IDX_W-1:0] w_idx;
    logic signed [8:0]  w_line;
    logic [7:0]         w_cd_base;
    logic               w_data_wr;

    logic               w_vid_we;
    logic [ADDR_W-1:0]  w_vid_waddr;
    logic [7:0]         w_vid_wdata;
    logic [7:0]         w_vid_rdata;
    logic               w_pal_we;
    logic [PAL_ADDR_W-1:0] w_pal_waddr;
    logic [COLOR_W-1:0] w_pal_wdata;
    logic [COLOR_W-1:0] w_pal_rdata;

    assign w_code     = i_value[7:6];
    assign w_idx      = i_value[MODE_IDX_W-1:0];
    assign w_ctl_addr = {i_value[5:0], r_latch};
    assign w_line     = $signed(i_next_line);
    assign w_cd_base  = (w_line == 9'sd0) ? r_mode[10] : r_cd;
    assign w_data_wr  = i_cmd.accept && (i_action == ACT_DATA_WR);

    assign o_sts.fill_req = (i_action == ACT_DATA_RD) ||
                            ((i_action == ACT_CTRL_WR) && r_sbe && (w_code == CODE_READ));
    assign o_sts.clr_last  = (r_clr_addr == {ADDR_W{1'b1}});
    assign o_sts.out_valid = r_out_valid;

    assign w_fill_addr = (i_action == ACT_DATA_RD) ? r_addr : w_ctl_addr;

    always_comb begin
        n_addr  = r_addr;
        n_sbe   = r_sbe;
        n_latch = r_latch;
        n_psel  = r_psel;
        n_rbuf  = r_rbuf;
        n_flags = r_flags;
        n_lf    = r_lf;
        n_cd    = r_cd;
        n_mode  = r_mode;
        w_rd    = 8'd0;
        case (i_action)
            ACT_CTRL_WR: begin
                if (r_sbe) begin
                    n_psel = (w_code == CODE_PAL_WR);
                    n_addr = w_ctl_addr;
                    n_sbe  = 1'b0;
                    if (w_code == CODE_REG_WR) begin
                        if (w_idx < MODE_IDX_W'(NUM_MODE_REGS)) begin
                            n_mode[w_idx] = r_latch;
                        end
                    end else if (w_code == CODE_READ) begin
                        n_addr = w_ctl_addr + ADDR_W'(1);
                    end
                end else begin
                    n_latch = i_value;
                    n_addr  = {r_addr[ADDR_W-1:8], i_value};
                    n_sbe   = 1'b1;
                end
            end
            ACT_DATA_WR: begin
                n_sbe  = 1'b0;
                n_rbuf = i_value;
                n_addr = r_addr + ADDR_W'(1);
            end
            ACT_DATA_RD: begin
                w_rd   = r_rbuf;
                n_sbe  = 1'b0;
                n_addr = r_addr + ADDR_W'(1);
            end
            ACT_STAT_RD: begin
                w_rd    = {r_flags, 5'd0};
                n_flags = 3'd0;
                n_lf    = 1'b0;
                n_sbe   = 1'b0;
            end
            ACT_FLAGS: begin
                n_flags = r_flags | {1'b0, i_set_overflow, i_set_collision};
            end
            ACT_LINE: begin
                if (w_line == 9'(FRAME_LINE)) begin
                    n_flags = r_flags | 3'b100;
                end
                if (w_line inside {[9'sd0:9'sd192]}) begin
                    if (w_cd_base == 8'd0) begin
                        n_lf = 1'b1;
                        n_cd = r_mode[10];
                    end else begin
                        n_cd = w_cd_base - 8'd1;
                    end
                end
            end
            default: begin
                w_rd = 8'd0;
            end
        endcase
        w_irq = (n_mode[1][5] && n_flags[2]) || (n_mode[0][4] && n_lf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_sbe       <= 1'b0;
            r_latch     <= 8'd0;
            r_psel      <= 1'b0;
            r_rbuf      <= 8'd0;
            r_flags     <= 3'd0;
            r_lf        <= 1'b0;
            r_cd        <= 8'd0;
            r_mode      <= '{default: 8'd0};
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_addr  <= n_addr;
                r_sbe   <= n_sbe;
                r_latch <= n_latch;
                r_psel  <= n_psel;
                r_flags <= n_flags;
                r_lf    <= n_lf;
                r_cd    <= n_cd;
                r_mode  <= n_mode;
            end
            if (i_cmd.fill) begin
                r_rbuf <= w_vid_rdata;
            end else if (i_cmd.accept) begin
                r_rbuf <= n_rbuf;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.accept) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_rd  <= w_rd;
            r_out_irq <= w_irq;
        end
        r_pal_raddr <= w_pal_waddr;
    end

    // clear pass zeroes both memories; palette wraps over its 32 entries
    assign w_vid_we    = i_cmd.clr_step || (w_data_wr && !r_psel);
    assign w_vid_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign w_vid_wdata = i_cmd.clr_step ? 8'd0 : i_value;
    assign w_pal_we    = i_cmd.clr_step || (w_data_wr && r_psel);
    assign w_pal_waddr = i_cmd.clr_step ? r_clr_addr[PAL_ADDR_W-1:0]
                                        : r_addr[PAL_ADDR_W-1:0];
    assign w_pal_wdata = i_cmd.clr_step ? '0 : expand_color(i_value[5:0]);

    vpri_ram #(
        .WIDTH (8),
        .DEPTH (VIDEO_MEM_DEPTH)
    ) u_video_ram (
        .i_clk   (i_clk),
        .i_we    (w_vid_we),
        .i_waddr (w_vid_waddr),
        .i_wdata (w_vid_wdata),
        .i_raddr (w_fill_addr),
        .o_rdata (w_vid_rdata)
    );

    // palette read port reads the write address of the previous cycle (write check)
    vpri_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (w_pal_waddr),
        .i_wdata (w_pal_wdata),
        .i_raddr (r_pal_raddr),
        .o_rdata (w_pal_rdata)
    );

    assign o_read_data = r_out_rd;
    assign o_irq       = r_out_irq;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_pal_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pal_we |-> ##2 (w_pal_rdata == $past(w_pal_wdata, 2)))
        else $error("palette entry not stored");
    a_addr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_data_wr |=> (r_addr == $past(r_addr) + ADDR_W'(1)))
        else $error("address did not advance on data write");
    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && (i_action == ACT_STAT_RD)) |=>
            ((r_flags == 3'd0) && !r_lf && !r_sbe))
        else $error("status read did not clear flags");
`endif

endmodule

@@ sv/video_port_register_interface.sv @@
// Top level of the video port register interface: unpacks the stream
// items and joins the sequencer (vpri_ctrl) to the datapath (vpri_dp).
//
//  channel   dir  tdata fields (low bit up)                        tuser
//  s_axis    in   value[7:0] next_line[16:8] set_overflow[17]     action[2:0]
//                 set_collision[18], zero fill to 24
//  m_axis    out  read_data[7:0] irq[8], zero fill to 16          -
//
// After reset both memories are cleared while s_axis_tready is held low.
// A data read or a read-setup control byte is followed by a refill state
// that loads the read buffer from the video memory port.
// The output register takes one result; a new item is accepted in the cycle
// that result is taken. Reset is synchronous, active low.
module video_port_register_interface import vpri_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // value, next_line, set_overflow, set_collision
    input  logic [2:0]  i_s_axis_tuser,  // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // read_data, irq
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;
    logic [7:0] w_read_data;
    logic       w_irq;

    vpri_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_s_ready (o_s_axis_tready)
    );

    vpri_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_s_axis_tuser),
        .i_value         (i_s_axis_tdata[7:0]),
        .i_next_line     (i_s_axis_tdata[16:8]),
        .i_set_overflow  (i_s_axis_tdata[17]),
        .i_set_collision (i_s_axis_tdata[18]),
        .o_sts           (w_sts),
        .o_read_data     (w_read_data),
        .o_irq           (w_irq),
        .o_out_valid     (o_m_axis_tvalid)
    );

    assign o_m_axis_tdata = {7'd0, w_irq, w_read_data};

endmodule
